FILE: rtl/info_frame_deframer_with_ack_top_assert.svh
// Assertion macros used by the deframer core, ifd_core.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef INFO_FRAME_DEFRAMER_WITH_ACK_TOP_ASSERT_SVH
`define INFO_FRAME_DEFRAMER_WITH_ACK_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ifd_pkg.sv
// Shared types and constants of the info frame deframer.
// No dependencies.
`default_nettype none

package ifd_pkg;

    // Size limit of the data field
    localparam int MAX_PAYLOAD = 1024;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;

    // Line bytes
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h5D;

    // Control bytes
    localparam logic [BYTE_W-1:0] CTRL_I0   = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_I1   = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_DISC = 8'h0B;
    localparam logic [BYTE_W-1:0] CTRL_RR0  = 8'h05;
    localparam logic [BYTE_W-1:0] CTRL_RR1  = 8'h85;
    localparam logic [BYTE_W-1:0] CTRL_REJ0 = 8'h01;
    localparam logic [BYTE_W-1:0] CTRL_REJ1 = 8'h81;

    localparam logic [BYTE_W-1:0] STATION_ADDR_RST = 8'h03;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        V_ACCEPTED   = 3'd0,
        V_CHECK_ERR  = 3'd1,
        V_ESCAPE_ERR = 3'd2,
        V_EMPTY      = 3'd3,
        V_DUPLICATE  = 3'd4,
        V_DISCONNECT = 3'd5,
        V_OVERFLOW   = 3'd6
    } verdict_t;

    // One result item
    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        verdict_t          verdict;
        logic              send_reply;
        logic [BYTE_W-1:0] reply_control;
        logic [LEN_W-1:0]  payload_length;
    } ifd_result_t;

endpackage

`default_nettype wire

FILE: rtl/info_frame_deframer_with_ack_top.sv
// Stop-and-wait information frame receiver. One received byte is taken per
// transfer and up to one byte per cycle is sustained while the result side is
// ready: the byte passes an input register with a skid entry, then the parser
// updates its state and loads the result register in the same cycle. The loop
// through the parser state registers sets the rate. Each unstuffed data byte but
// the last, the XOR check byte, appears when the next one arrives; the closing flag
// yields one verdict with the reply control byte and payload length.
// Depends on ifd_pkg, ifd_skid and ifd_core.
`default_nettype none

module info_frame_deframer_with_ack_top
    import ifd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_rx_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_result_kind,
    output logic [BYTE_W-1:0]      m_payload_byte,
    output logic [2:0]             m_verdict,
    output logic                   m_send_reply,
    output logic [BYTE_W-1:0]      m_reply_control,
    output logic [LEN_W-1:0]       m_payload_length
);

    logic              byte_valid;
    logic              byte_ready;
    logic [BYTE_W-1:0] byte_data;
    ifd_result_t       res;

    // Register the incoming byte stream
    ifd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_rx_byte),
        .out_valid (byte_valid),
        .out_ready (byte_ready),
        .out_data  (byte_data)
    );

    // Parse and produce results
    ifd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (byte_valid),
        .in_ready  (byte_ready),
        .in_byte   (byte_data),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_result_kind    = res.result_kind;
    assign m_payload_byte   = res.payload_byte;
    assign m_verdict        = res.verdict;
    assign m_send_reply     = res.send_reply;
    assign m_reply_control  = res.reply_control;
    assign m_payload_length = res.payload_length;

endmodule

`default_nettype wire

FILE: rtl/ifd_skid.sv
// Input register stage with a skid entry for the received byte stream.
// Depends on ifd_pkg.
`default_nettype none

module ifd_skid
    import ifd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic [BYTE_W-1:0] main_data_reg;
    logic [BYTE_W-1:0] skid_data_reg;
    logic              in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Advance the main entry when it drains, park a transfer in the skid entry otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_data_reg  <= skid_data_reg;
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_fire;
                if (in_fire) begin
                    main_data_reg <= in_data;
                end
            end
        end else if (in_fire) begin
            skid_data_reg  <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ifd_core.sv
// Frame parser: header hunt, unstuffing, running XOR, verdict and result register.
// Depends on ifd_pkg and info_frame_deframer_with_ack_top_assert.svh.
`default_nettype none

`include "info_frame_deframer_with_ack_top_assert.svh"

module ifd_core
    import ifd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output ifd_result_t            res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] addr_reg;
    logic              exp_seq_reg, exp_seq_next;
    logic              frame_seq_reg, frame_seq_next;
    logic              esc_pend_reg, esc_pend_next;
    logic              esc_err_reg, esc_err_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              res_valid_reg;
    ifd_result_t       res_reg, res_next;
    logic              emit;
    logic              accept_frame;
    logic              in_fire;
    logic              u_valid;
    logic [BYTE_W-1:0] u_byte;
    logic [BYTE_W-1:0] hdr_check;

    assign in_ready  = !res_valid_reg || res_ready;
    assign in_fire   = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign hdr_check = addr_reg ^ (frame_seq_reg ? CTRL_I1 : CTRL_I0);

    // Unstuff the incoming data byte
    always_comb begin
        u_valid = 1'b0;
        u_byte  = in_byte;
        if (esc_pend_reg) begin
            if (in_byte == ESC_FLAG) begin
                u_valid = 1'b1;
                u_byte  = FLAG_BYTE;
            end else if (in_byte == ESC_ESC) begin
                u_valid = 1'b1;
                u_byte  = ESC_BYTE;
            end
        end else if (in_byte != ESC_BYTE) begin
            u_valid = 1'b1;
        end
    end

    // Next state and result for one byte
    always_comb begin
        phase_next      = phase_reg;
        exp_seq_next    = exp_seq_reg;
        frame_seq_next  = frame_seq_reg;
        esc_pend_next   = esc_pend_reg;
        esc_err_next    = esc_err_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        cnt_next        = cnt_reg;
        emit            = 1'b0;
        accept_frame    = 1'b0;
        res_next        = '0;
        unique case (phase_reg)
            PH_HUNT: begin
                if (in_byte == FLAG_BYTE) begin
                    phase_next = PH_FLAG;
                end
            end
            PH_FLAG: begin
                if (in_byte == addr_reg) begin
                    phase_next = PH_ADDR;
                end else if (in_byte != FLAG_BYTE) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_ADDR: begin
                if (in_byte == CTRL_I0 || in_byte == CTRL_I1) begin
                    frame_seq_next = (in_byte == CTRL_I1);
                    phase_next     = PH_CTRL;
                end else if (in_byte == CTRL_DISC) begin
                    emit                   = 1'b1;
                    res_next.result_kind   = KIND_VERDICT;
                    res_next.verdict       = V_DISCONNECT;
                    res_next.send_reply    = 1'b1;
                    res_next.reply_control = CTRL_DISC;
                    phase_next             = PH_HUNT;
                end else if (in_byte == FLAG_BYTE) begin
                    phase_next = PH_FLAG;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (in_byte == hdr_check) begin
                    esc_pend_next   = 1'b0;
                    esc_err_next    = 1'b0;
                    held_valid_next = 1'b0;
                    xor_next        = '0;
                    cnt_next        = '0;
                    phase_next      = PH_DATA;
                end else if (in_byte == FLAG_BYTE) begin
                    phase_next = PH_FLAG;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (in_byte == FLAG_BYTE) begin
                    // Closing flag: one verdict, then hunt again
                    emit                    = 1'b1;
                    res_next.result_kind    = KIND_VERDICT;
                    res_next.send_reply     = 1'b1;
                    res_next.payload_length = LEN_W'(cnt_reg);
                    phase_next              = PH_HUNT;
                    if (frame_seq_reg != exp_seq_reg) begin
                        res_next.verdict       = V_DUPLICATE;
                        res_next.reply_control = exp_seq_reg ? CTRL_RR1 : CTRL_RR0;
                    end else if (esc_err_reg || esc_pend_reg) begin
                        res_next.verdict       = V_ESCAPE_ERR;
                        res_next.reply_control = exp_seq_reg ? CTRL_REJ1 : CTRL_REJ0;
                    end else if (!held_valid_reg) begin
                        res_next.verdict       = V_EMPTY;
                        res_next.reply_control = exp_seq_reg ? CTRL_REJ1 : CTRL_REJ0;
                    end else if (held_byte_reg != xor_reg) begin
                        res_next.verdict       = V_CHECK_ERR;
                        res_next.reply_control = exp_seq_reg ? CTRL_REJ1 : CTRL_REJ0;
                    end else begin
                        res_next.verdict       = V_ACCEPTED;
                        res_next.reply_control = exp_seq_reg ? CTRL_RR0 : CTRL_RR1;
                        exp_seq_next           = !exp_seq_reg;
                        accept_frame           = 1'b1;
                    end
                end else if (!esc_err_reg) begin
                    if (esc_pend_reg) begin
                        esc_pend_next = 1'b0;
                        esc_err_next  = !u_valid;
                    end else if (in_byte == ESC_BYTE) begin
                        esc_pend_next = 1'b1;
                    end
                    if (u_valid) begin
                        if (!held_valid_reg) begin
                            held_byte_next  = u_byte;
                            held_valid_next = 1'b1;
                        end else if (cnt_reg >= CNT_W'(MAX_PAYLOAD)) begin
                            // Frame too long: end it with no reply
                            emit                    = 1'b1;
                            res_next.result_kind    = KIND_VERDICT;
                            res_next.verdict        = V_OVERFLOW;
                            res_next.payload_length = LEN_W'(cnt_reg);
                            phase_next              = PH_HUNT;
                        end else begin
                            // Release the held byte, hold the new one
                            emit                  = 1'b1;
                            res_next.result_kind  = KIND_PAYLOAD;
                            res_next.payload_byte = held_byte_reg;
                            xor_next              = xor_reg ^ held_byte_reg;
                            cnt_next              = cnt_reg + 1'b1;
                            held_byte_next        = u_byte;
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Hold parser state, configuration and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            addr_reg       <= STATION_ADDR_RST;
            exp_seq_reg    <= 1'b0;
            frame_seq_reg  <= 1'b0;
            esc_pend_reg   <= 1'b0;
            esc_err_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            xor_reg        <= '0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                addr_reg <= cfg_wdata;
            end
            if (in_fire) begin
                phase_reg      <= phase_next;
                exp_seq_reg    <= exp_seq_next;
                frame_seq_reg  <= frame_seq_next;
                esc_pend_reg   <= esc_pend_next;
                esc_err_reg    <= esc_err_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                xor_reg        <= xor_next;
                cnt_reg        <= cnt_next;
                res_valid_reg  <= emit;
                if (emit) begin
                    res_reg <= res_next;
                end
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    `IFD_ASSERT_NOW(a_payload_clean,
        res_valid_reg && res_reg.result_kind == KIND_PAYLOAD,
        res_reg.verdict == V_ACCEPTED && !res_reg.send_reply &&
        res_reg.reply_control == '0 && res_reg.payload_length == '0,
        "payload result carries verdict fields")
    `IFD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_PAYLOAD),
        "payload count beyond limit")
    `IFD_ASSERT_NOW(a_esc_exclusive, 1'b1, !(esc_pend_reg && esc_err_reg),
        "escape pending and escape error both set")
    `IFD_ASSERT_NEXT(a_seq_toggle, in_fire && accept_frame,
        exp_seq_reg != $past(exp_seq_reg), "accepted frame did not toggle sequence")
    `IFD_ASSERT_NEXT(a_seq_hold, !(in_fire && accept_frame), $stable(exp_seq_reg),
        "sequence bit changed without an accepted frame")

endmodule

`default_nettype wire

FILE: tb/info_frame_deframer_with_ack_top_tb.sv
// Self-checking testbench for info_frame_deframer_with_ack_top: directed frames, then
// random frame traffic, checked against a cycle-free predictor of the deframer.
// Depends on ifd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module info_frame_deframer_with_ack_top_tb;
    import ifd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BYTES = 260;
    localparam int PHASE_BYTES  = 130;
    localparam int DRAIN_CYCLES = 6;

    typedef logic [BYTE_W-1:0] octet_t;

    typedef enum logic [2:0] {
        RX_HUNT, RX_FLAG, RX_ADDR, RX_CTRL, RX_DATA
    } rx_phase_t;

    typedef enum int {
        FAULT_NONE, FAULT_CHECK, FAULT_ESCAPE, FAULT_DANGLING, FAULT_EMPTY
    } frame_fault_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    octet_t            cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    octet_t            s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_result_kind;
    octet_t            m_payload_byte;
    logic [2:0]        m_verdict;
    logic              m_send_reply;
    octet_t            m_reply_control;
    logic [LEN_W-1:0]  m_payload_length;

    // Predictor state
    octet_t      stn_addr = STATION_ADDR_RST;
    rx_phase_t   rx_phase = RX_HUNT;
    logic        exp_seq = 1'b0;
    logic        frm_seq = 1'b0;
    logic        esc_pend = 1'b0;
    logic        esc_err = 1'b0;
    octet_t      held = '0;
    logic        held_ok = 1'b0;
    octet_t      xor_acc = '0;
    int          pay_cnt = 0;

    ifd_result_t deframed_q[$];
    octet_t      line_q[$];
    octet_t      data_q[$];

    bit          no_gaps = 1'b0;
    int          stall = 0;
    int          err_cnt = 0;
    int          line_xfer_cnt = 0;
    int          payload_seen = 0;
    int          verdict_seen[8];
    int          cycle_count = 0;

    info_frame_deframer_with_ack_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_payload_byte   (m_payload_byte),
        .m_verdict        (m_verdict),
        .m_send_reply     (m_send_reply),
        .m_reply_control  (m_reply_control),
        .m_payload_length (m_payload_length)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_frame();
        esc_pend = 1'b0;
        esc_err  = 1'b0;
        held     = '0;
        held_ok  = 1'b0;
        xor_acc  = '0;
        pay_cnt  = 0;
    endtask

    // Closing flag: pick one verdict, duplicate first, then escape, empty, check
    task automatic close_frame();
        ifd_result_t r;
        r = '0;
        r.result_kind    = KIND_VERDICT;
        r.send_reply     = 1'b1;
        r.payload_length = LEN_W'(pay_cnt);
        if (frm_seq != exp_seq) begin
            r.verdict       = V_DUPLICATE;
            r.reply_control = exp_seq ? CTRL_RR1 : CTRL_RR0;
        end else if (esc_err || esc_pend) begin
            r.verdict       = V_ESCAPE_ERR;
            r.reply_control = exp_seq ? CTRL_REJ1 : CTRL_REJ0;
        end else if (!held_ok) begin
            r.verdict       = V_EMPTY;
            r.reply_control = exp_seq ? CTRL_REJ1 : CTRL_REJ0;
        end else if (held != xor_acc) begin
            r.verdict       = V_CHECK_ERR;
            r.reply_control = exp_seq ? CTRL_REJ1 : CTRL_REJ0;
        end else begin
            r.verdict       = V_ACCEPTED;
            r.reply_control = exp_seq ? CTRL_RR0 : CTRL_RR1;
            exp_seq         = ~exp_seq;
        end
        deframed_q.push_back(r);
        rx_phase = RX_HUNT;
        clear_frame();
    endtask

    // Data field byte: unstuff, then release the byte held one place back
    task automatic data_byte(input octet_t b);
        ifd_result_t r;
        octet_t      u;
        logic        have_u;
        r      = '0;
        u      = b;
        have_u = 1'b0;
        if (!esc_err) begin
            if (esc_pend) begin
                esc_pend = 1'b0;
                if (b == ESC_FLAG) begin
                    u      = FLAG_BYTE;
                    have_u = 1'b1;
                end else if (b == ESC_ESC) begin
                    u      = ESC_BYTE;
                    have_u = 1'b1;
                end else begin
                    esc_err = 1'b1;
                end
            end else if (b == ESC_BYTE) begin
                esc_pend = 1'b1;
            end else begin
                have_u = 1'b1;
            end
        end
        if (have_u) begin
            if (!held_ok) begin
                held    = u;
                held_ok = 1'b1;
            end else if (pay_cnt >= MAX_PAYLOAD) begin
                r.result_kind    = KIND_VERDICT;
                r.verdict        = V_OVERFLOW;
                r.payload_length = LEN_W'(pay_cnt);
                deframed_q.push_back(r);
                rx_phase = RX_HUNT;
                clear_frame();
            end else begin
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = held;
                deframed_q.push_back(r);
                xor_acc = xor_acc ^ held;
                pay_cnt++;
                held = u;
            end
        end
    endtask

    // Advance the receiver by one line byte
    task automatic deframe_byte(input octet_t b);
        ifd_result_t r;
        r = '0;
        case (rx_phase)
            RX_HUNT: begin
                if (b == FLAG_BYTE) begin
                    clear_frame();
                    rx_phase = RX_FLAG;
                end
            end
            RX_FLAG: begin
                if (b == stn_addr) begin
                    rx_phase = RX_ADDR;
                end else if (b == FLAG_BYTE) begin
                    clear_frame();
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_ADDR: begin
                if (b == CTRL_I0 || b == CTRL_I1) begin
                    frm_seq  = (b == CTRL_I1);
                    rx_phase = RX_CTRL;
                end else if (b == CTRL_DISC) begin
                    r.result_kind   = KIND_VERDICT;
                    r.verdict       = V_DISCONNECT;
                    r.send_reply    = 1'b1;
                    r.reply_control = CTRL_DISC;
                    deframed_q.push_back(r);
                    rx_phase = RX_HUNT;
                    clear_frame();
                end else if (b == FLAG_BYTE) begin
                    clear_frame();
                    rx_phase = RX_FLAG;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_CTRL: begin
                if (b == (stn_addr ^ (frm_seq ? CTRL_I1 : CTRL_I0))) begin
                    clear_frame();
                    rx_phase = RX_DATA;
                end else if (b == FLAG_BYTE) begin
                    clear_frame();
                    rx_phase = RX_FLAG;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_DATA: begin
                if (b == FLAG_BYTE) begin
                    close_frame();
                end else begin
                    data_byte(b);
                end
            end
            default: rx_phase = RX_HUNT;
        endcase
    endtask

    // ---------------------------------------------------------------- result side

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want != got) begin
            $display("%0t ERROR %s mismatch: expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_result();
        ifd_result_t want;
        bit          ok;
        if (deframed_q.size() == 0) begin
            $display("%0t ERROR unexpected result: kind %0d byte 0x%02h verdict %0d",
                     $time, m_result_kind, m_payload_byte, m_verdict);
            err_cnt++;
        end else begin
            want = deframed_q.pop_front();
            ok = field_ok("result_kind", want.result_kind, m_result_kind)
               & field_ok("payload_byte", want.payload_byte, m_payload_byte)
               & field_ok("verdict", want.verdict, m_verdict)
               & field_ok("send_reply", want.send_reply, m_send_reply)
               & field_ok("reply_control", want.reply_control, m_reply_control)
               & field_ok("payload_length", want.payload_length, m_payload_length);
            if (!ok)
                err_cnt++;
            if (want.result_kind == KIND_PAYLOAD)
                payload_seen++;
            else
                verdict_seen[want.verdict]++;
        end
    endtask

    // Check each result transfer, then hold ready low for a random stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall = 0;
        end else if (m_valid && m_ready) begin
            check_result();
            stall = no_gaps ? 0 : $urandom_range(0, 17);
        end else if (stall > 0) begin
            stall--;
        end
        m_ready <= (stall == 0);
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("info_frame_deframer_with_ack_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------- line side

    // One line byte: optional gap, then hold valid until the transfer
    task automatic send_rx_byte(input octet_t b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_byte(b);
        line_xfer_cnt++;
    endtask

    task automatic send_line();
        while (line_q.size() != 0)
            send_rx_byte(line_q.pop_front());
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_station_address(input octet_t a);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        stn_addr = a;
    endtask

    // ---------------------------------------------------------------- frame building

    function automatic octet_t rand_data();
        octet_t specials[4];
        specials = '{FLAG_BYTE, ESC_BYTE, ESC_FLAG, ESC_ESC};
        if ($urandom_range(0, 7) == 0)
            return specials[$urandom_range(0, 3)];
        return octet_t'($urandom_range(0, 255));
    endfunction

    task automatic fill_data(input int n);
        data_q.delete();
        repeat (n) data_q.push_back(rand_data());
    endtask

    task automatic push_stuffed(input octet_t b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(b == FLAG_BYTE ? ESC_FLAG : ESC_ESC);
        end else begin
            line_q.push_back(b);
        end
    endtask

    task automatic push_bad_escape();
        octet_t b;
        do b = octet_t'($urandom_range(0, 255));
        while (b == ESC_FLAG || b == ESC_ESC || b == FLAG_BYTE);
        line_q.push_back(ESC_BYTE);
        line_q.push_back(b);
    endtask

    // I frame around data_q, with the requested fault, onto the line
    task automatic build_iframe(input octet_t addr, input logic seq,
                                input frame_fault_t fault);
        octet_t ctl;
        octet_t chk;
        int     bad_at;
        ctl    = seq ? CTRL_I1 : CTRL_I0;
        chk    = '0;
        bad_at = (fault == FAULT_ESCAPE) ? $urandom_range(0, data_q.size()) : -1;
        line_q.push_back(FLAG_BYTE);
        line_q.push_back(addr);
        line_q.push_back(ctl);
        line_q.push_back(addr ^ ctl);
        if (fault != FAULT_EMPTY) begin
            for (int i = 0; i < data_q.size(); i++) begin
                if (i == bad_at)
                    push_bad_escape();
                push_stuffed(data_q[i]);
                chk = chk ^ data_q[i];
            end
            if (bad_at == data_q.size())
                push_bad_escape();
            if (fault == FAULT_CHECK)
                chk = chk ^ octet_t'($urandom_range(1, 255));
            push_stuffed(chk);
            if (fault == FAULT_DANGLING)
                line_q.push_back(ESC_BYTE);
        end
        line_q.push_back(FLAG_BYTE);
        send_line();
    endtask

    task automatic build_disc(input octet_t addr);
        line_q = {FLAG_BYTE, addr, CTRL_DISC};
        send_line();
    endtask

    // ---------------------------------------------------------------- tests

    // Accepted frame with extreme and stuffed bytes, a duplicate, a disconnect
    task automatic test_basic_frames();
        data_q = {8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE};
        build_iframe(stn_addr, 1'b0, FAULT_NONE);
        data_q.delete();
        build_iframe(stn_addr, 1'b0, FAULT_EMPTY);
        build_disc(stn_addr);
    endtask

    // Stray flags after flag, address and control; wrong address; closing flag not reused
    task automatic test_header_quirks();
        line_q = {FLAG_BYTE, FLAG_BYTE, stn_addr, FLAG_BYTE, stn_addr, CTRL_I1, FLAG_BYTE,
                  stn_addr, CTRL_I1, stn_addr ^ CTRL_I1, 8'h5A, 8'h5A, FLAG_BYTE,
                  stn_addr, CTRL_I0, stn_addr ^ CTRL_I0, 8'h11, 8'h11, FLAG_BYTE,
                  FLAG_BYTE, 8'h55, stn_addr, CTRL_I0};
        send_line();
    endtask

    // Check, escape and dangling escape faults; duplicate wins over an escape fault
    task automatic test_verdict_order();
        data_q = {8'h12, 8'h34};
        build_iframe(stn_addr, exp_seq, FAULT_CHECK);
        build_iframe(stn_addr, exp_seq, FAULT_ESCAPE);
        build_iframe(stn_addr, exp_seq, FAULT_DANGLING);
        build_iframe(stn_addr, ~exp_seq, FAULT_ESCAPE);
    endtask

    // Address extremes, including header bytes that equal the flag
    task automatic test_station_addresses();
        octet_t addrs[5];
        addrs = '{8'h00, 8'hFF, FLAG_BYTE, FLAG_BYTE ^ CTRL_I1, STATION_ADDR_RST};
        foreach (addrs[i]) begin
            write_station_address(addrs[i]);
            fill_data(3);
            build_iframe(stn_addr, exp_seq, FAULT_NONE);
            build_iframe(stn_addr, exp_seq, FAULT_NONE);
            build_disc(stn_addr);
        end
    endtask

    // One byte past the longest data field: a full payload count, then overflow
    task automatic test_length_limits();
        no_gaps = 1'b1;
        fill_data(MAX_PAYLOAD + 1);
        build_iframe(stn_addr, exp_seq, FAULT_NONE);
        no_gaps = 1'b0;
    endtask

    // Mostly well-formed frames with random content, some faults and line noise
    task automatic test_random_traffic();
        octet_t addrs[5];
        int     stop_at;
        int     phase_end;
        int     pick;
        int     n;
        addrs   = '{8'h00, 8'hFF, FLAG_BYTE, FLAG_BYTE ^ CTRL_I1, STATION_ADDR_RST};
        stop_at = line_xfer_cnt + RANDOM_BYTES;
        while (line_xfer_cnt < stop_at) begin
            no_gaps = 1'b0;
            if ($urandom_range(0, 3) == 0)
                write_station_address(addrs[$urandom_range(0, 4)]);
            else
                write_station_address(octet_t'($urandom_range(0, 255)));
            phase_end = line_xfer_cnt + PHASE_BYTES;
            while (line_xfer_cnt < phase_end && line_xfer_cnt < stop_at) begin
                no_gaps = ($urandom_range(0, 5) == 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(0, 12);
                fill_data(n);
                if ($urandom_range(0, 7) == 0) begin
                    line_q.push_back(FLAG_BYTE);
                    send_line();
                end
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    build_iframe(stn_addr, exp_seq, FAULT_NONE);
                end else if (pick < 65) begin
                    build_iframe(stn_addr, ~exp_seq, FAULT_NONE);
                end else if (pick < 73) begin
                    build_iframe(stn_addr, exp_seq, FAULT_CHECK);
                end else if (pick < 79) begin
                    build_iframe(stn_addr, exp_seq, FAULT_ESCAPE);
                end else if (pick < 82) begin
                    build_iframe(stn_addr, exp_seq, FAULT_DANGLING);
                end else if (pick < 86) begin
                    build_iframe(stn_addr, exp_seq, FAULT_EMPTY);
                end else if (pick < 90) begin
                    build_disc(stn_addr);
                end else if (pick < 95) begin
                    // broken header: cut short after flag, address or control
                    line_q.push_back(FLAG_BYTE);
                    if ($urandom_range(0, 1) == 0)
                        line_q.push_back(stn_addr);
                    if ($urandom_range(0, 1) == 0)
                        line_q.push_back($urandom_range(0, 1) ? CTRL_I1 : CTRL_I0);
                    repeat ($urandom_range(1, 3))
                        line_q.push_back(octet_t'($urandom_range(0, 255)));
                    send_line();
                end else begin
                    repeat ($urandom_range(1, 4)) line_q.push_back(rand_data());
                    send_line();
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_frames();
        test_header_quirks();
        test_verdict_order();
        test_station_addresses();
        test_length_limits();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d line bytes over several station addresses; checked %0d payload bytes.",
                 line_xfer_cnt, payload_seen);
        $display("Verdicts: accepted %0d, check %0d, escape %0d, empty %0d,",
                 verdict_seen[V_ACCEPTED], verdict_seen[V_CHECK_ERR],
                 verdict_seen[V_ESCAPE_ERR], verdict_seen[V_EMPTY]);
        $display("          dup %0d, disc %0d, overflow %0d",
                 verdict_seen[V_DUPLICATE], verdict_seen[V_DISCONNECT],
                 verdict_seen[V_OVERFLOW]);
        if (err_cnt == 0)
            $display("info_frame_deframer_with_ack_top regression: pass");
        else
            $display("info_frame_deframer_with_ack_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ifd_pkg.sv
rtl/ifd_skid.sv
rtl/ifd_core.sv
rtl/info_frame_deframer_with_ack_top.sv
tb/info_frame_deframer_with_ack_top_tb.sv
